@@ rtl/maf_pkg.sv @@
// ----------------------------------------------------------------------------
// maf_pkg
// Shared widths and helpers for the moving-average filter.
// ----------------------------------------------------------------------------
`default_nettype none

package maf_pkg;

  localparam int MAX_WINDOW = 32;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_W      = 8;
  // window length holds 1..MAX_WINDOW, fill count 0..MAX_WINDOW
  localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
  localparam int SLOT_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  // sum of MAX_WINDOW full-scale samples
  localparam int SUM_W      = SAMPLE_W + ((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1);
  localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

  // zero or out-of-range window acts as a window of one
  function automatic logic [WIN_W-1:0] eff_window(input logic [CFG_W-1:0] cfg);
    logic [WIN_W-1:0] res;
    if (cfg == '0 || int'(cfg) > MAX_WINDOW) begin
      res = WIN_W'(1);
    end else begin
      res = WIN_W'(cfg);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/moving_average_filter.sv @@
// ----------------------------------------------------------------------------
// moving_average_filter
// Running mean over the last N samples, ring of samples held in a RAM.
// ----------------------------------------------------------------------------
// a taken sample word passes S_READ (sum, fill and ring update), then the bit-serial
// divider in S_DIV, before the result word is registered; one sample is in flight, and
// a sample is taken again once the previous result is loaded in the output reg
// reset (sync, active high): window 1, sum, fill count and write slot cleared
// a window write clears the same state; ring entries are always rewritten
// before they are read, so the RAM needs no clearing pass
`default_nettype none

module moving_average_filter (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [maf_pkg::CFG_W-1:0]     window_length,
  input  wire logic                          sample_valid,
  output logic                               sample_stall,
  input  wire logic [maf_pkg::SAMPLE_W-1:0]  sample,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic      [maf_pkg::SAMPLE_W-1:0]  average,
  output logic                               ready_res
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIV
  } state_t;

  state_t                         state;
  logic [maf_pkg::WIN_W-1:0]      eff;
  logic [maf_pkg::SUM_W-1:0]      sum;
  logic [maf_pkg::WIN_W-1:0]      fill;
  logic [maf_pkg::SLOT_W-1:0]     slot;
  logic [maf_pkg::SAMPLE_W-1:0]   sample_q;
  logic                           full_q;

  logic [maf_pkg::SAMPLE_W-1:0]   old_sample;
  logic [maf_pkg::SUM_W-1:0]      sum_next;
  logic [maf_pkg::WIN_W-1:0]      fill_next;
  logic [maf_pkg::WIN_W-1:0]      slot_inc;
  logic [maf_pkg::SLOT_W-1:0]     slot_next;
  logic                           ring_we;
  logic                           div_start;
  logic                           div_busy;
  logic [maf_pkg::SUM_W-1:0]      quotient;
  logic                           sample_acc;
  logic                           out_free;
  logic                           out_load;
  logic                           cfg_wr;

  // window writes only land while no sample is in flight
  assign cfg_ready    = (state == S_IDLE);
  assign cfg_wr       = cfg_valid && cfg_ready;
  // a pending window write goes ahead of the next sample word
  assign sample_stall = (state != S_IDLE) || cfg_valid;
  assign sample_acc   = sample_valid && !sample_stall;
  assign out_free     = !result_valid || !result_stall;
  assign out_load     = (state == S_DIV) && !div_busy && out_free;
  assign ring_we      = (state == S_READ);
  assign div_start    = (state == S_READ);

  // while filling the sum only grows; once full the oldest word drops out
  always_comb begin
    if (fill < eff) begin
      sum_next  = sum + maf_pkg::SUM_W'(sample_q);
      fill_next = fill + 1'b1;
    end else begin
      sum_next  = sum - maf_pkg::SUM_W'(old_sample) + maf_pkg::SUM_W'(sample_q);
      fill_next = fill;
    end
    slot_inc = maf_pkg::WIN_W'(slot) + maf_pkg::WIN_W'(1);
    if (slot_inc == eff) begin
      slot_next = '0;
    end else begin
      slot_next = maf_pkg::SLOT_W'(slot_inc);
    end
  end

  maf_ram #(
    .WIDTH (maf_pkg::SAMPLE_W),
    .DEPTH (maf_pkg::MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (slot),
    .wdata (sample_q),
    .raddr (slot),
    .rdata (old_sample)
  );

  maf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (fill_next),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      eff          <= maf_pkg::eff_window(maf_pkg::CFG_W'(1));
      sum          <= '0;
      fill         <= '0;
      slot         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (cfg_wr) begin
        eff  <= maf_pkg::eff_window(window_length);
        sum  <= '0;
        fill <= '0;
        slot <= '0;
      end
      case (state)
        S_IDLE: begin
          if (sample_acc) begin
            sample_q <= sample;
            state    <= S_READ;
          end
        end
        S_READ: begin
          sum    <= sum_next;
          fill   <= fill_next;
          slot   <= slot_next;
          full_q <= (fill_next >= eff);
          state  <= S_DIV;
        end
        S_DIV: begin
          if (out_load) begin
            average   <= quotient[maf_pkg::SAMPLE_W-1:0];
            ready_res <= full_q;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= eff)
    else $error("fill count beyond window");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    maf_pkg::WIN_W'(slot) < eff)
    else $error("write slot outside window");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    sample_acc |=> sample_stall && !div_busy)
    else $error("second sample word taken before the first was processed");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");
`endif

endmodule

`default_nettype wire

@@ rtl/maf_ram.sv @@
// ----------------------------------------------------------------------------
// maf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module maf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/maf_div.sv @@
// ----------------------------------------------------------------------------
// maf_div
// Restoring divider, one quotient bit per cycle: running sum over fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module maf_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [maf_pkg::SUM_W-1:0]   dividend,
  input  wire logic [maf_pkg::WIN_W-1:0]   divisor,
  output logic                             busy,
  output logic      [maf_pkg::SUM_W-1:0]   quotient
);

  logic [maf_pkg::WIN_W-1:0]     rem;
  logic [maf_pkg::WIN_W-1:0]     dvs;
  logic [maf_pkg::DIV_CNT_W-1:0] cnt;
  logic [maf_pkg::WIN_W:0]       shifted;
  logic [maf_pkg::WIN_W:0]       diff;

  assign busy    = (cnt != '0);
  assign shifted = {rem, quotient[maf_pkg::SUM_W-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt      <= maf_pkg::DIV_CNT_W'(maf_pkg::SUM_W);
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      // no borrow means the shifted remainder covers the divisor
      if (!diff[maf_pkg::WIN_W]) begin
        rem      <= diff[maf_pkg::WIN_W-1:0];
        quotient <= {quotient[maf_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem      <= shifted[maf_pkg::WIN_W-1:0];
        quotient <= {quotient[maf_pkg::SUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire
